### rtl/clmgr_pkg.sv
// ----------------------------------------------------------------------------
// clmgr_pkg: shared types, constants and bitmap tables for the line, marker
// and glyph rasterizer.
// ----------------------------------------------------------------------------
package clmgr_pkg;

  localparam int unsigned CoordW    = 7;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned GlyphSize = 9;
  localparam int unsigned MarkSize  = 5;
  localparam int unsigned MarkCount = 13;
  localparam logic [23:0] White     = 24'hFFFFFF;
  localparam logic [7:0]  CharOpen  = 8'h28;
  localparam logic [7:0]  CharClose = 8'h29;
  localparam logic [7:0]  CharZero  = 8'h30;
  localparam logic [7:0]  CharNine  = 8'h39;

  typedef enum logic [1:0] {
    MODE_LINE   = 2'd0,
    MODE_MARKER = 2'd1,
    MODE_GLYPH  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LSETUP,
    ST_LDIV,
    ST_LPIX,
    ST_LRD,
    ST_LWAIT,
    ST_LWR,
    ST_STAMP,
    ST_READ,
    ST_RWAIT,
    ST_OUT
  } state_e;

  // Glyph rows, column 0 in bit 8.
  function automatic logic [8:0] glyph_row(input logic [3:0] g, input logic [3:0] r);
    logic [8:0] t [0:11][0:8];
    t[0]  = '{9'h000,9'h038,9'h044,9'h044,9'h08A,9'h0A2,9'h044,9'h044,9'h038};
    t[1]  = '{9'h000,9'h010,9'h030,9'h050,9'h010,9'h010,9'h010,9'h010,9'h0FE};
    t[2]  = '{9'h000,9'h078,9'h084,9'h084,9'h008,9'h010,9'h020,9'h040,9'h0FE};
    t[3]  = '{9'h000,9'h07C,9'h082,9'h004,9'h018,9'h004,9'h002,9'h082,9'h07C};
    t[4]  = '{9'h000,9'h020,9'h020,9'h048,9'h048,9'h0FE,9'h008,9'h008,9'h008};
    t[5]  = '{9'h000,9'h0FC,9'h080,9'h080,9'h078,9'h004,9'h002,9'h084,9'h078};
    t[6]  = '{9'h000,9'h038,9'h044,9'h080,9'h0B8,9'h0C4,9'h082,9'h082,9'h07C};
    t[7]  = '{9'h000,9'h0FE,9'h082,9'h004,9'h008,9'h010,9'h010,9'h010,9'h010};
    t[8]  = '{9'h000,9'h07C,9'h082,9'h082,9'h07C,9'h082,9'h082,9'h082,9'h07C};
    t[9]  = '{9'h000,9'h07C,9'h082,9'h082,9'h07E,9'h002,9'h002,9'h084,9'h078};
    t[10] = '{9'h000,9'h002,9'h004,9'h008,9'h008,9'h008,9'h008,9'h004,9'h002};
    t[11] = '{9'h000,9'h080,9'h040,9'h020,9'h020,9'h020,9'h020,9'h040,9'h080};
    if (g < 4'd12 && r < 4'd9) return t[g][r];
    return 9'h000;
  endfunction

  // Marker rows, column 0 in bit 4.
  function automatic logic [4:0] mark_row(input logic [3:0] s, input logic [2:0] r);
    logic [4:0] t [0:12][0:4];
    t[0]  = '{5'h00,5'h0E,5'h0E,5'h0E,5'h00};
    t[1]  = '{5'h0E,5'h1B,5'h11,5'h1B,5'h0E};
    t[2]  = '{5'h00,5'h1C,5'h0E,5'h07,5'h00};
    t[3]  = '{5'h1F,5'h0E,5'h04,5'h00,5'h00};
    t[4]  = '{5'h00,5'h00,5'h04,5'h0E,5'h1F};
    t[5]  = '{5'h0C,5'h0C,5'h0C,5'h00,5'h0C};
    t[6]  = '{5'h00,5'h00,5'h1F,5'h00,5'h00};
    t[7]  = '{5'h00,5'h1F,5'h00,5'h1F,5'h00};
    t[8]  = '{5'h1F,5'h00,5'h1F,5'h00,5'h1F};
    t[9]  = '{5'h04,5'h04,5'h04,5'h04,5'h04};
    t[10] = '{5'h04,5'h0C,5'h1C,5'h0C,5'h04};
    t[11] = '{5'h04,5'h06,5'h07,5'h06,5'h04};
    t[12] = '{5'h04,5'h0E,5'h15,5'h0E,5'h04};
    if (s < 4'd13 && r < 3'd5) return t[s][r];
    return 5'h00;
  endfunction

endpackage

### rtl/canvas_line_marker_glyph_raster.sv
// ----------------------------------------------------------------------------
// canvas_line_marker_glyph_raster
// Antialiased line, marker and glyph rasterizer over a white-cleared frame
// memory, with a pixel read command.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | mode, coordinates, color, codes
//  out     | output    | out_valid/out_ready| pixel_color (read command only)
//
//  After reset the frame memory is cleared one pixel a cycle; in_ready
//  rises once every pixel is white.
//  Line: a setup state, then per major step a serial divide, a position step
//  and two read-modify-writes (ST_LRD, ST_LWAIT, ST_LWR) through the single
//  memory port. Marker and glyph: one table cell per cycle.
//  Read: address in ST_READ, data registered in ST_RWAIT, result held in
//  ST_OUT for as long as out_ready stalls it.
module canvas_line_marker_glyph_raster
  import clmgr_pkg::*;
#(
  parameter int unsigned CANVAS_WIDTH  = 128,
  parameter int unsigned CANVAS_HEIGHT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode_i,
  input  logic [6:0]  first_x_i,
  input  logic [6:0]  first_y_i,
  input  logic [6:0]  second_x_i,
  input  logic [6:0]  second_y_i,
  input  logic [23:0] draw_color_i,
  input  logic [3:0]  marker_shape_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] pixel_color_o
);

  localparam int unsigned XW    = $clog2(CANVAS_WIDTH);
  localparam int unsigned YW    = $clog2(CANVAS_HEIGHT);
  localparam int unsigned Depth = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int unsigned AW    = XW + YW;

  // Frame memory, row-major, address y*CANVAS_WIDTH+x.
  logic [23:0] mem_q [Depth];
  logic [23:0] rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [23:0] mem_wdata;
  logic [AW:0] clr_q;

  state_e state_q, state_d;

  // Latched command.
  logic [1:0]  mode_q;
  logic [23:0] color_q;
  logic [3:0]  shape_q;
  logic [3:0]  gidx_q;
  logic        gok_q;
  logic [7:0]  bx_q, by_q;   // signed 8-bit base coordinates

  // Line state.
  logic        xmaj_q;
  logic [6:0]  a0_q, d_q, i_q;
  logic [6:0]  b0_q;
  logic        eneg_q;
  logic [6:0]  emag_q;
  // Serial divider for the line steps: (i*|e|*256) / d.
  logic [21:0] rem_q;
  logic [14:0] quo_q;
  logic [21:0] num_q;
  logic [4:0]  dcnt_q;
  logic [7:0]  w_q;
  logic [7:0]  m_q;          // minor integer (0..127)
  logic        sel_q;        // 0: pixel m, 1: pixel m+1
  logic [3:0]  r_q, c_q;     // stamp walk
  logic [23:0] res_q;

  // Current pixel coordinates, signed 11 bits.
  logic signed [10:0] px, py;
  logic        on_cv;
  always_comb begin
    logic signed [10:0] maj, mnr;
    maj = $signed({4'd0, a0_q}) + $signed({4'd0, i_q});
    mnr = $signed({3'd0, m_q}) + $signed({10'd0, sel_q});
    px  = 11'sd0;
    py  = 11'sd0;
    if (state_q == ST_STAMP) begin
      px = $signed({{3{bx_q[7]}}, bx_q}) + $signed({7'd0, c_q});
      py = $signed({{3{by_q[7]}}, by_q}) + $signed({7'd0, r_q});
    end else if (state_q == ST_READ || state_q == ST_RWAIT) begin
      px = $signed({4'd0, bx_q[6:0]});
      py = $signed({4'd0, by_q[6:0]});
    end else if (xmaj_q) begin
      px = maj; py = mnr;
    end else begin
      px = mnr; py = maj;
    end
    on_cv = (px >= 0) && (py >= 0) && (px < CANVAS_WIDTH) && (py < CANVAS_HEIGHT);
  end

  logic [AW-1:0] pix_addr;
  assign pix_addr = AW'(py[YW-1:0]) * AW'(CANVAS_WIDTH) + AW'(px[XW-1:0]);

  // Stamp bit for current cell.
  logic stamp_bit, stamp_last;
  always_comb begin
    logic [8:0] grow;
    logic [4:0] mrow;
    grow = glyph_row(gidx_q, r_q);
    mrow = mark_row(shape_q, r_q[2:0]);
    if (mode_q == MODE_GLYPH) begin
      stamp_bit  = gok_q && grow[4'd8 - c_q];
      stamp_last = (r_q == 4'd8) && (c_q == 4'd8);
    end else begin
      stamp_bit  = mrow[3'(4'd4 - c_q)];
      stamp_last = (r_q == 4'd4) && (c_q == 4'd4);
    end
  end

  // Blend: weight for pixel m is 256-w, for m+1 is w (9-bit).
  logic [8:0]  wt;
  logic [23:0] blend;
  always_comb begin
    logic [16:0] v;
    wt = sel_q ? {1'b0, w_q} : (9'd256 - {1'b0, w_q});
    for (int k = 0; k < 3; k++) begin
      v = 17'(color_q[k*8 +: 8]) * 17'(wt) +
          17'(rdata_q[k*8 +: 8]) * (17'd256 - 17'(wt));
      blend[k*8 +: 8] = v[15:8];
    end
  end

  // Memory port select.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pix_addr;
    mem_wdata = color_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q[AW-1:0];
        mem_wdata = White;
      end
      ST_STAMP: mem_we = stamp_bit && on_cv;
      ST_LWR: begin
        mem_we    = on_cv;
        mem_wdata = blend;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rdata_q <= mem_q[mem_addr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == (AW+1)'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          case (mode_e'(mode_i))
            MODE_LINE:   state_d = ST_LSETUP;
            MODE_READ:   state_d = ST_READ;
            default:     state_d = ST_STAMP;
          endcase
        end
      end
      ST_LSETUP: state_d = ST_LDIV;
      ST_LDIV:   if (dcnt_q == 5'd0) state_d = ST_LPIX;
      ST_LPIX:   state_d = ST_LRD;
      ST_LRD:    state_d = ST_LWAIT;
      ST_LWAIT:  state_d = ST_LWR;
      ST_LWR: begin
        if (!sel_q)          state_d = ST_LRD;
        else if (i_q == d_q) state_d = ST_IDLE;
        else                 state_d = ST_LDIV;
      end
      ST_STAMP:  if (stamp_last) state_d = ST_IDLE;
      ST_READ:   state_d = ST_RWAIT;
      ST_RWAIT:  state_d = ST_OUT;
      ST_OUT:    if (out_ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready      = (state_q == ST_IDLE);
    out_valid     = (state_q == ST_OUT);
    pixel_color_o = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    logic signed [7:0] dx, dy, e;
    logic [6:0]  adx, ady;
    logic [22:0] trial;
    logic [15:0] pos;
    logic [3:0]  gi;
    logic        gk;
    case (state_q)
      ST_IDLE: begin
        if (in_valid) begin
          mode_q  <= mode_i;
          color_q <= draw_color_i;
          shape_q <= marker_shape_i;
          r_q <= '0;
          c_q <= '0;
          if (mode_i == MODE_MARKER) begin
            bx_q <= {1'b0, first_x_i} - 8'd2;
            by_q <= {1'b0, first_y_i} - 8'd2;
          end else begin
            bx_q <= {1'b0, first_x_i};
            by_q <= {1'b0, first_y_i};
          end
          // Map the character to a glyph index.
          gk = 1'b1;
          gi = 4'(char_code_i - CharZero);
          if (char_code_i == CharOpen)       gi = 4'd10;
          else if (char_code_i == CharClose) gi = 4'd11;
          else if (char_code_i < CharZero || char_code_i > CharNine) gk = 1'b0;
          gok_q  <= gk;
          gidx_q <= gi;
          // Order endpoints along the major axis.
          dx  = $signed({1'b0, second_x_i}) - $signed({1'b0, first_x_i});
          dy  = $signed({1'b0, second_y_i}) - $signed({1'b0, first_y_i});
          adx = dx[7] ? 7'(-dx) : dx[6:0];
          ady = dy[7] ? 7'(-dy) : dy[6:0];
          xmaj_q <= adx >= ady;
          if (adx >= ady) begin
            if (dx[7]) begin
              a0_q <= second_x_i; b0_q <= second_y_i; e = -dy;
            end else begin
              a0_q <= first_x_i;  b0_q <= first_y_i;  e = dy;
            end
            d_q <= adx;
          end else begin
            if (dy[7]) begin
              a0_q <= second_y_i; b0_q <= second_x_i; e = -dx;
            end else begin
              a0_q <= first_y_i;  b0_q <= first_x_i;  e = dx;
            end
            d_q <= ady;
          end
          eneg_q <= e[7];
          emag_q <= e[7] ? 7'(-e) : e[6:0];
          i_q    <= '0;
          num_q  <= '0;
        end
      end
      ST_LSETUP: begin
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= 5'd22;
      end
      // Restoring divide, one quotient bit per cycle; rounds toward -inf
      // for a negative numerator via a remainder correction at the end.
      ST_LDIV: begin
        if (dcnt_q != 5'd0) begin
          trial = {rem_q, num_q[5'(dcnt_q - 5'd1)]};
          if (d_q != 7'd0 && trial >= 23'(d_q)) begin
            rem_q <= 22'(trial - 23'(d_q));
            quo_q <= {quo_q[13:0], 1'b1};
          end else begin
            rem_q <= trial[21:0];
            quo_q <= {quo_q[13:0], 1'b0};
          end
          dcnt_q <= dcnt_q - 5'd1;
        end
      end
      ST_LPIX: begin
        if (!eneg_q)
          pos = {1'b0, b0_q, 8'd0} + {1'b0, quo_q};
        else if (rem_q != 0)
          pos = {1'b0, b0_q, 8'd0} - {1'b0, quo_q} - 16'd1;
        else
          pos = {1'b0, b0_q, 8'd0} - {1'b0, quo_q};
        if (pos[15]) pos = '0;
        m_q   <= {1'b0, pos[14:8]};
        w_q   <= pos[7:0];
        sel_q <= 1'b0;
      end
      ST_LWR: begin
        if (!sel_q) sel_q <= 1'b1;
        else begin
          i_q    <= i_q + 7'd1;
          num_q  <= num_q + {7'd0, emag_q, 8'd0};
          rem_q  <= '0;
          quo_q  <= '0;
          dcnt_q <= 5'd22;
        end
      end
      ST_STAMP: begin
        if ((mode_q == MODE_GLYPH && c_q == 4'd8) ||
            (mode_q == MODE_MARKER && c_q == 4'd4)) begin
          c_q <= '0;
          r_q <= r_q + 4'd1;
        end else c_q <= c_q + 4'd1;
      end
      // Return zero for a position outside the canvas.
      ST_RWAIT: res_q <= on_cv ? rdata_q : 24'd0;
      default: ;
    endcase
  end

endmodule

### rtl/clmgr_checker.sv
// ----------------------------------------------------------------------------
// clmgr_checker: port-level checks for the rasterizer.
// Watches the handshakes and the one-command-at-a-time behavior.
// ----------------------------------------------------------------------------
module clmgr_checker
  import clmgr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  mode_i,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] pixel_color_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pixel_color_o))
    else $error("result changed while stalled");

  // Never take a command while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("ready while result pending");

  // After a drawing transfer, neither a result nor in_ready follows next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && mode_i != MODE_READ |=> !out_valid && !in_ready)
    else $error("unexpected state after draw command");

  // A read transfer yields its result once it has passed ST_READ and ST_RWAIT.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && mode_i == MODE_READ |=> ##2 out_valid)
    else $error("read result missing");

endmodule

bind canvas_line_marker_glyph_raster clmgr_checker u_clmgr_checker (
  .clk_i, .rst_ni, .in_valid, .in_ready, .mode_i,
  .out_valid, .out_ready, .pixel_color_o
);

### tb/canvas_line_marker_glyph_raster_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canvas_line_marker_glyph_raster_tb
// Sends line, marker, glyph and pixel-read commands to the rasterizer. A
// shadow frame store follows every drawing command, so each pixel read can
// be checked against the expected color. Both sides of the handshake idle at
// random, over several phases.
// ----------------------------------------------------------------------------
module canvas_line_marker_glyph_raster_tb;
  import clmgr_pkg::*;

  localparam int CanvasW    = 128;
  localparam int CanvasH    = 128;
  localparam int CycleLimit = 4000000;

  // Shadow of the frame store and the queue of pending pixel reads.
  class raster_scoreboard;
    logic [23:0] shadow [0:CanvasW*CanvasH-1];
    logic [23:0] pending_reads [$];
    int errors;

    function void clear_shadow();
      for (int k = 0; k < CanvasW*CanvasH; k++) shadow[k] = White;
      errors = 0;
    endfunction

    function void plot(int x, int y, logic [23:0] color);
      if (x >= 0 && y >= 0 && x < CanvasW && y < CanvasH) shadow[y*CanvasW+x] = color;
    endfunction

    function void blend(int x, int y, logic [23:0] color, int w);
      logic [23:0] old;
      logic [23:0] mixed;
      int c;
      int o;
      if (x < 0 || y < 0 || x >= CanvasW || y >= CanvasH) return;
      old = shadow[y*CanvasW+x];
      for (int sh = 0; sh <= 16; sh += 8) begin
        c = (color >> sh) & 8'hFF;
        o = (old >> sh) & 8'hFF;
        mixed[sh +: 8] = 8'((c*w + o*(256-w)) >> 8);
      end
      shadow[y*CanvasW+x] = mixed;
    endfunction

    function void trace_line(int x0, int y0, int x1, int y1, logic [23:0] color);
      int dx, dy, a0, a1, b0, b1, d, e, t, q, pos, m, w, num;
      bit xmajor;
      dx = x1 - x0;
      dy = y1 - y0;
      xmajor = ((dx < 0) ? -dx : dx) >= ((dy < 0) ? -dy : dy);
      a0 = xmajor ? x0 : y0;
      a1 = xmajor ? x1 : y1;
      b0 = xmajor ? y0 : x0;
      b1 = xmajor ? y1 : x1;
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      d = a1 - a0;
      e = b1 - b0;
      for (int i = 0; i <= d; i++) begin
        num = i * e * 256;
        if (d == 0) q = 0;
        else if (num >= 0) q = num / d;
        else q = -((-num + d - 1) / d);
        pos = b0*256 + q;
        if (pos < 0) pos = 0;
        m = pos >> 8;
        w = pos & 8'hFF;
        if (xmajor) begin
          blend(a0+i, m, color, 256-w);
          blend(a0+i, m+1, color, w);
        end else begin
          blend(m, a0+i, color, 256-w);
          blend(m+1, a0+i, color, w);
        end
      end
    endfunction

    // Apply one accepted command to the shadow store.
    function void note_command(mode_e mode, int fx, int fy, int sx, int sy,
                               logic [23:0] color, logic [3:0] shape,
                               logic [7:0] code);
      int g;
      case (mode)
        MODE_LINE: trace_line(fx, fy, sx, sy, color);
        MODE_MARKER: begin
          if (shape < MarkCount)
            for (int r = 0; r < MarkSize; r++)
              for (int c = 0; c < MarkSize; c++)
                if (mark_bits(shape, r) & (5'h10 >> c)) plot(fx+c-2, fy+r-2, color);
        end
        MODE_GLYPH: begin
          g = -1;
          if (code >= CharZero && code <= CharNine) g = code - CharZero;
          else if (code == CharOpen) g = 10;
          else if (code == CharClose) g = 11;
          if (g >= 0)
            for (int r = 0; r < GlyphSize; r++)
              for (int c = 0; c < GlyphSize; c++)
                if (glyph_bits(g, r) & (9'h100 >> c)) plot(fx+c, fy+r, color);
        end
        default: pending_reads.push_back(shadow[fy*CanvasW+fx]);
      endcase
    endfunction

    function void check_pixel(logic [23:0] got);
      logic [23:0] want;
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel 0x%06h", got));
        return;
      end
      want = pending_reads.pop_front();
      if (got !== want)
        report_mismatch($sformatf("pixel_color 0x%06h, expected 0x%06h", got, want));
    endfunction

    function void report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endfunction

    function logic [4:0] mark_bits(int s, int r);
      logic [4:0] t [0:12][0:4];
      t[0]  = '{5'h00,5'h0E,5'h0E,5'h0E,5'h00};
      t[1]  = '{5'h0E,5'h1B,5'h11,5'h1B,5'h0E};
      t[2]  = '{5'h00,5'h1C,5'h0E,5'h07,5'h00};
      t[3]  = '{5'h1F,5'h0E,5'h04,5'h00,5'h00};
      t[4]  = '{5'h00,5'h00,5'h04,5'h0E,5'h1F};
      t[5]  = '{5'h0C,5'h0C,5'h0C,5'h00,5'h0C};
      t[6]  = '{5'h00,5'h00,5'h1F,5'h00,5'h00};
      t[7]  = '{5'h00,5'h1F,5'h00,5'h1F,5'h00};
      t[8]  = '{5'h1F,5'h00,5'h1F,5'h00,5'h1F};
      t[9]  = '{5'h04,5'h04,5'h04,5'h04,5'h04};
      t[10] = '{5'h04,5'h0C,5'h1C,5'h0C,5'h04};
      t[11] = '{5'h04,5'h06,5'h07,5'h06,5'h04};
      t[12] = '{5'h04,5'h0E,5'h15,5'h0E,5'h04};
      return t[s][r];
    endfunction

    function logic [8:0] glyph_bits(int g, int r);
      logic [8:0] t [0:11][0:8];
      t[0]  = '{9'h000,9'h038,9'h044,9'h044,9'h08A,9'h0A2,9'h044,9'h044,9'h038};
      t[1]  = '{9'h000,9'h010,9'h030,9'h050,9'h010,9'h010,9'h010,9'h010,9'h0FE};
      t[2]  = '{9'h000,9'h078,9'h084,9'h084,9'h008,9'h010,9'h020,9'h040,9'h0FE};
      t[3]  = '{9'h000,9'h07C,9'h082,9'h004,9'h018,9'h004,9'h002,9'h082,9'h07C};
      t[4]  = '{9'h000,9'h020,9'h020,9'h048,9'h048,9'h0FE,9'h008,9'h008,9'h008};
      t[5]  = '{9'h000,9'h0FC,9'h080,9'h080,9'h078,9'h004,9'h002,9'h084,9'h078};
      t[6]  = '{9'h000,9'h038,9'h044,9'h080,9'h0B8,9'h0C4,9'h082,9'h082,9'h07C};
      t[7]  = '{9'h000,9'h0FE,9'h082,9'h004,9'h008,9'h010,9'h010,9'h010,9'h010};
      t[8]  = '{9'h000,9'h07C,9'h082,9'h082,9'h07C,9'h082,9'h082,9'h082,9'h07C};
      t[9]  = '{9'h000,9'h07C,9'h082,9'h082,9'h07E,9'h002,9'h002,9'h084,9'h078};
      t[10] = '{9'h000,9'h002,9'h004,9'h008,9'h008,9'h008,9'h008,9'h004,9'h002};
      t[11] = '{9'h000,9'h080,9'h040,9'h020,9'h020,9'h020,9'h020,9'h040,9'h080};
      return t[g][r];
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode_i = '0;
  logic [6:0]  first_x_i = '0;
  logic [6:0]  first_y_i = '0;
  logic [6:0]  second_x_i = '0;
  logic [6:0]  second_y_i = '0;
  logic [23:0] draw_color_i = '0;
  logic [3:0]  marker_shape_i = '0;
  logic [7:0]  char_code_i = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] pixel_color_o;

  raster_scoreboard board;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_req = 0;
  int  hold_done = 0;
  int  hold_cycles = 0;
  int  cycle_count = 0;

  canvas_line_marker_glyph_raster uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Count cycles and stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive out_ready, with a long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (hold_done != hold_req) begin
      hold_cycles <= 3000;
      hold_done <= hold_req;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) board.check_pixel(pixel_color_o);
  end

  // Offer one command and wait for its transfer.
  task automatic send_command(mode_e mode, int fx, int fy, int sx, int sy,
                              logic [23:0] color, logic [3:0] shape, logic [7:0] code);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    mode_i <= mode;
    first_x_i <= 7'(fx);
    first_y_i <= 7'(fy);
    second_x_i <= 7'(sx);
    second_y_i <= 7'(sy);
    draw_color_i <= color;
    marker_shape_i <= shape;
    char_code_i <= code;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    board.note_command(mode, fx, fy, sx, sy, color, shape, code);
  endtask

  task automatic read_at(int x, int y);
    send_command(MODE_READ, x, y, 0, 0, 24'($urandom), 4'($urandom), 8'($urandom));
  endtask

  // Send one command of random kind; draws are followed by reads near them.
  task automatic random_command();
    int pick, fx, fy, len;
    logic [23:0] color;
    pick = $urandom_range(99);
    fx = $urandom_range(127);
    fy = $urandom_range(127);
    color = 24'($urandom);
    if (pick < 25) begin
      // Mostly short lines keep the run fast.
      len = ($urandom_range(19) == 0) ? 127 : 12;
      send_command(MODE_LINE, fx, fy,
                   (len == 127) ? $urandom_range(127) : (fx + $urandom_range(len)) % 128,
                   (len == 127) ? $urandom_range(127) : (fy + $urandom_range(len)) % 128,
                   color, 4'($urandom), 8'($urandom));
      repeat (3) read_at((fx + $urandom_range(6)) % 128, (fy + $urandom_range(6)) % 128);
    end else if (pick < 40) begin
      send_command(MODE_MARKER, fx, fy, 0, 0, color, 4'($urandom), 8'($urandom));
      read_at((fx + 126 + $urandom_range(4)) % 128, (fy + 126 + $urandom_range(4)) % 128);
    end else if (pick < 55) begin
      send_command(MODE_GLYPH, fx, fy, 0, 0, color, 4'($urandom),
                   ($urandom_range(3) == 0) ? 8'($urandom) : 8'(CharOpen + $urandom_range(17)));
      read_at((fx + $urandom_range(8)) % 128, (fy + $urandom_range(8)) % 128);
    end else begin
      read_at(fx, fy);
    end
  endtask

  // Drop valid and wait until every expected result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_reads.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    board = new();
    board.clear_shadow();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every marker and glyph, zero-length and edge lines.
    read_at(0, 0);
    read_at(127, 127);
    send_command(MODE_LINE, 5, 5, 5, 5, 24'h123456, 4'd0, 8'd0);
    read_at(5, 5);
    send_command(MODE_LINE, 0, 127, 127, 0, 24'h000000, 4'd0, 8'd0);
    send_command(MODE_LINE, 127, 120, 0, 127, 24'hFFFFFF, 4'd0, 8'd0);
    send_command(MODE_LINE, 127, 127, 120, 0, 24'h80FF01, 4'd0, 8'd0);
    read_at(126, 1);
    read_at(127, 127);
    for (int s = 0; s < 16; s++)
      send_command(MODE_MARKER, (s * 9) % 128, (s == 0) ? 127 : 1, 0, 0,
                   24'h00FF00 ^ 24'(s), 4'(s), 8'd0);
    read_at(0, 127);
    for (int g = 0; g < 12; g++)
      send_command(MODE_GLYPH, 122, g * 10, 0, 0, 24'h0000FF,
                   4'd0, (g < 10) ? 8'(CharZero + g) : ((g == 10) ? CharOpen : CharClose));
    send_command(MODE_GLYPH, 60, 60, 0, 0, 24'hFF0000, 4'd0, 8'hFF);
    read_at(124, 2);
    read_at(124, 3);
    wait_drained();

    // Random phases: none, slow sender, slow receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 81 : (phase == 3) ? 38 : 0;
      recv_stall_pct = (phase == 2) ? 81 : (phase == 3) ? 38 : 0;
      if (phase == 0) hold_req <= hold_req + 1;
      for (int n = 0; n < 110; n++) random_command();
      wait_drained();
    end

    // Let the block finish any drawing before judging.
    repeat (4000) @(posedge clk_i);
    if (board.pending_reads.size() != 0)
      board.report_mismatch("reads left without a result");
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
